FILE: design/msgr_pkg.sv
package msgr_pkg;

   localparam int MAX_STOPS = 8;
   localparam int IDX_W     = $clog2(MAX_STOPS);
   localparam int CNT_W     = 4;
   localparam int VAL_W     = 16;
   localparam int NUM_CH    = 4;
   localparam int CH_W      = $clog2(NUM_CH);
   localparam int FRAC_W    = 15;

   localparam logic [VAL_W-1:0] Q_ONE = 16'h8000;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef logic [NUM_CH-1:0][VAL_W-1:0] color_type;

   typedef struct packed {
      logic [VAL_W-1:0] pos;
      color_type        color;
   } stop_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LAST,
      ST_CHK_FIRST,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   function automatic logic [VAL_W-1:0] sat_q(input logic [VAL_W-1:0] v);
      sat_q = (v > Q_ONE) ? Q_ONE : v;
   endfunction

endpackage

FILE: design/msgr_div.sv
module msgr_div
   import msgr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] num,
   input  logic [VAL_W-1:0] den,
   output logic             done,
   output logic [VAL_W-1:0] quot
);

   // Restoring divider for (num << 15) / den with num <= den, so the
   // quotient fits in VAL_W bits. One quotient bit per cycle.
   localparam int STEP_W = $clog2(VAL_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [VAL_W:0]    rem_ff, rem_in;
   logic [VAL_W-1:0]  den_ff, den_in;
   logic [VAL_W-1:0]  quot_ff, quot_in;
   logic              ge;
   logic [VAL_W:0]    rem_sub;

   always_comb begin
      ge      = rem_ff >= {1'b0, den_ff};
      rem_sub = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(VAL_W - 1);
         rem_in  = {1'b0, num};
         den_in  = den;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VAL_W-2:0], ge};
         rem_in  = {rem_sub[VAL_W-1:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: design/multi_stop_gradient_ramp.sv
// Multi-stop gradient ramp.
// The req channel carries one word per item. tuser selects the kind: a write
// word loads one stop (position and RGBA color) into the eight-entry stop
// table and gives no result; a query word asks for the color at sample_t.
// The rsp channel returns one RGBA word per query, each channel Q1.15 and
// saturated to 1.0. The csr channel writes the number of stops in use; it is
// always ready. The user must write it only while the block is idle; the block
// does not enforce this. A query walks the table one stop per cycle through a
// single registered read port, then runs a bit-serial divider for the weight
// (16 steps) and four passes through one shared multiplier, one per channel.
// A query that lands on an end stop skips the scan and the divider; an
// interpolated one goes through both.
// req_tready is low from the acceptance of a query until its result has been
// moved into the output register. If the receiver stalls, the result waits
// there and the block can take and finish the next item up to its own
// result. Reset sets the stop count to one and leaves the table unwritten.
module multi_stop_gradient_ramp
   import msgr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // stop_index[2:0], stop_pos[18:3], stop_red[34:19], stop_green[50:35],
   // stop_blue[66:51], stop_alpha[82:67], sample_t[98:83], zero fill above
   input  logic [103:0]       req_tdata,
   // req_type
   input  logic               req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48]
   output logic [63:0]        rsp_tdata,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CNT_W-1:0]   csr_data
);

   logic [2:0]       in_index;
   stop_entry_type   in_entry;
   logic [VAL_W-1:0] in_t;

   assign in_index       = req_tdata[2:0];
   assign in_entry.pos   = req_tdata[18:3];
   assign in_entry.color = req_tdata[82:19];
   assign in_t           = req_tdata[98:83];

   stop_entry_type stop_mem [MAX_STOPS];
   stop_entry_type rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [VAL_W-1:0]       t_ff, t_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic                   ge_last_ff, ge_last_in;
   logic [VAL_W-1:0]       prev_pos_ff, prev_pos_in;
   color_type              prev_col_ff, prev_col_in;
   color_type              cur_col_ff, cur_col_in;
   logic [VAL_W-1:0]       w_ff, w_in;
   logic [CH_W-1:0]        ch_ff, ch_in;
   logic signed [33:0]     prod_ff, prod_in;
   color_type              res_ff, res_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   color_type              rsp_tdata_ff, rsp_tdata_in;

   logic [CNT_W-1:0]       count_used;
   logic [IDX_W-1:0]       last_idx;
   logic                   div_start;
   logic [VAL_W-1:0]       div_num, div_den;
   logic                   div_done;
   logic [VAL_W-1:0]       div_quot;
   logic signed [16:0]     diff;
   logic signed [33:0]     acc;
   logic                   out_free;

   msgr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      if (count_ff == '0) begin
         count_used = CNT_W'(1);
      end else if (count_ff > CNT_W'(MAX_STOPS)) begin
         count_used = CNT_W'(MAX_STOPS);
      end else begin
         count_used = count_ff;
      end
      last_idx = IDX_W'(count_used - CNT_W'(1));
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      t_in        = t_ff;
      k_in        = k_ff;
      ge_last_in  = ge_last_ff;
      prev_pos_in = prev_pos_ff;
      prev_col_in = prev_col_ff;
      cur_col_in  = cur_col_ff;
      w_in        = w_ff;
      ch_in       = ch_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      req_tready  = 1'b0;
      mem_we      = 1'b0;
      div_start   = 1'b0;
      div_num     = t_ff - prev_pos_ff;
      div_den     = rd_ff.pos - prev_pos_ff;
      rd_addr     = k_ff + IDX_W'(1);
      diff        = $signed({1'b0, cur_col_ff[ch_ff]}) - $signed({1'b0, prev_col_ff[ch_ff]});
      acc         = $signed({3'b000, prev_col_ff[ch_ff], {FRAC_W{1'b0}}}) + prod_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      if (csr_valid) begin
         count_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = last_idx;
            if (req_tvalid) begin
               if (req_tuser == REQ_WRITE) begin
                  mem_we = {1'b0, in_index} < (IDX_W + 1)'(MAX_STOPS);
               end else begin
                  t_in     = in_t;
                  state_in = ST_CHK_LAST;
               end
            end
         end
         ST_CHK_LAST: begin
            // The last in-use stop is in the read register now.
            rd_addr    = '0;
            ge_last_in = t_ff >= rd_ff.pos;
            cur_col_in = rd_ff.color;
            k_in       = '0;
            state_in   = ST_CHK_FIRST;
         end
         ST_CHK_FIRST: begin
            ch_in = '0;
            if (t_ff <= rd_ff.pos) begin
               prev_col_in = rd_ff.color;
               cur_col_in  = rd_ff.color;
               w_in        = '0;
               state_in    = ST_MUL;
            end else if (ge_last_ff) begin
               prev_col_in = cur_col_ff;
               w_in        = '0;
               state_in    = ST_MUL;
            end else begin
               prev_col_in = rd_ff.color;
               prev_pos_in = rd_ff.pos;
               k_in        = IDX_W'(1);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The walk stops at the last stop at the latest, since t lies below it here.
            if (t_ff > rd_ff.pos) begin
               prev_col_in = rd_ff.color;
               prev_pos_in = rd_ff.pos;
               k_in        = k_ff + IDX_W'(1);
            end else begin
               cur_col_in = rd_ff.color;
               div_start  = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               w_in     = div_quot;
               ch_in    = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = diff * $signed({1'b0, w_ff});
            state_in = ST_ACC;
         end
         ST_ACC: begin
            res_in[ch_ff] = sat_q(acc[30:15]);
            if (ch_ff == CH_W'(NUM_CH - 1)) begin
               state_in = ST_DONE;
            end else begin
               ch_in    = ch_ff + CH_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stop_mem[in_index] <= in_entry;
      end
      rd_ff <= stop_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= CNT_W'(1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      t_ff        <= t_in;
      k_ff        <= k_in;
      ge_last_ff  <= ge_last_in;
      prev_pos_ff <= prev_pos_in;
      prev_col_ff <= prev_col_in;
      cur_col_ff  <= cur_col_in;
      w_ff        <= w_in;
      ch_ff       <= ch_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTH
   a_out_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] <= Q_ONE) && (rsp_tdata[31:16] <= Q_ONE) &&
                     (rsp_tdata[47:32] <= Q_ONE) && (rsp_tdata[63:48] <= Q_ONE))
      else $error("result channel above 1.0");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && div_done |-> div_quot <= Q_ONE)
      else $error("interpolation weight above 1.0");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_QUERY) |=> state_ff == ST_CHK_LAST)
      else $error("accepted query did not start the table walk");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> rsp_tvalid && (state_ff == ST_IDLE))
      else $error("finished query not moved to the output register");
`endif

endmodule
